>>> sv/frtc_pkg.sv
// Package for the four-register toy CPU step block.
// Holds sizes, opcode and command codes, the slot layout and the FSM state type.
`timescale 1ns / 1ps
package frtc_pkg;
    localparam int IMEM_DEPTH_DEF = 256;
    localparam int DMEM_DEPTH_DEF = 256;
    localparam int REG_COUNT_DEF  = 4;

    typedef enum logic [1:0] {
        CMD_WR_SLOT = 2'd0,
        CMD_WR_DATA = 2'd1,
        CMD_STEP    = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_DIV   = 4'd3,
        OP_LOAD  = 4'd4,
        OP_STORE = 4'd5,
        OP_JMP   = 4'd6,
        OP_JEQ   = 4'd7,
        OP_JGT   = 4'd8,
        OP_JLT   = 4'd9,
        OP_WRITE = 4'd10,
        OP_READ  = 4'd11,
        OP_STOP  = 4'd12,
        OP_EMPTY = 4'd15
    } op_t;

    typedef struct packed {
        logic [3:0] op;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
    } slot_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EXEC,
        ST_DIV,
        ST_MEM,
        ST_OUT
    } state_t;
endpackage

>>> sv/frtc_if.sv
// Valid/ready channel interfaces for the toy CPU step block.
// Depends on nothing.
`timescale 1ns / 1ps
interface frtc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [7:0]         address;
    logic [3:0]         opcode;
    logic [7:0]         operand_a;
    logic [7:0]         operand_b;
    logic [7:0]         operand_c;
    logic signed [31:0] value;
    modport source (output valid, cmd, address, opcode, operand_a, operand_b,
                    operand_c, value, input ready);
    modport sink (input valid, cmd, address, opcode, operand_a, operand_b,
                  operand_c, value, output ready);
endinterface

interface frtc_out_if;
    logic               valid;
    logic               ready;
    logic [8:0]         pc_after;
    logic               halted;
    logic               out_valid;
    logic signed [31:0] out_value;
    logic               input_taken;
    logic               store_fault;
    logic [3:0]         done_opcode;
    modport source (output valid, pc_after, halted, out_valid, out_value,
                    input_taken, store_fault, done_opcode, input ready);
    modport sink (input valid, pc_after, halted, out_valid, out_value,
                  input_taken, store_fault, done_opcode, output ready);
endinterface

>>> sv/four_register_toy_cpu_step.sv
// Top level of the four-register toy CPU step block.
// Depends on frtc_pkg and the channel interfaces in frtc_if.sv.
//
// One item at a time. A slot write, a data write, an unknown command or a step while halted
// goes through the fetch and out states only. A step goes through fetch from the instruction
// memory, then execute and write back; a load adds one memory state for the load data, and a
// div adds the bit-serial divider. The next item can be accepted in the cycle after the result
// is taken. After reset a clearing pass empties both memories before the first item is
// accepted.
`timescale 1ns / 1ps
module four_register_toy_cpu_step
    import frtc_pkg::*;
#(
    parameter int IMEM_DEPTH = IMEM_DEPTH_DEF,
    parameter int DMEM_DEPTH = DMEM_DEPTH_DEF,
    parameter int REG_COUNT  = REG_COUNT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    frtc_in_if.sink    in_ch,
    frtc_out_if.source out_ch
);
    localparam int IAW = (IMEM_DEPTH > 1) ? $clog2(IMEM_DEPTH) : 1;
    localparam int DAW = (DMEM_DEPTH > 1) ? $clog2(DMEM_DEPTH) : 1;
    localparam int CLRN = (IMEM_DEPTH > DMEM_DEPTH) ? IMEM_DEPTH : DMEM_DEPTH;
    localparam int CW = $clog2(CLRN + 1);
    localparam int RW = $clog2(REG_COUNT);

    slot_t       imem [IMEM_DEPTH];
    logic [31:0] dmem [DMEM_DEPTH];
    logic [31:0] rf_reg [REG_COUNT];

    state_t state_reg, state_next;
    logic [CW-1:0] clr_reg;
    logic          clr_busy;
    logic [8:0]    pc_reg;
    logic [8:0]    pc_next;
    logic          stop_reg;

    logic [1:0]  cmd_reg;
    logic [7:0]  addr_reg;
    slot_t       wslot_reg;
    logic [31:0] val_reg;
    slot_t       slot_q;
    logic [31:0] dq;

    logic [5:0]  div_cnt_reg;
    logic [31:0] quo_reg, rem_reg, dvs_reg;
    logic        neg_reg;

    logic        o_valid_reg;
    logic [8:0]  o_pc_reg;
    logic        o_halt_reg, o_ov_reg, o_it_reg, o_sf_reg;
    logic [31:0] o_val_reg;
    logic [3:0]  o_op_reg;

    logic        halted_now;
    logic        accept;
    logic [RW-1:0] ra, rb, rc;
    logic [31:0] x, y, z;
    logic [31:0] prod;
    logic [32:0] rem_try;

    assign clr_busy   = (clr_reg != CW'(CLRN));
    assign halted_now = stop_reg || (pc_reg >= 9'(IMEM_DEPTH));
    assign in_ch.ready = (state_reg == ST_IDLE) && !clr_busy && !o_valid_reg;
    assign accept     = in_ch.valid && in_ch.ready;

    assign ra = slot_q.a[RW-1:0];
    assign rb = slot_q.b[RW-1:0];
    assign rc = slot_q.c[RW-1:0];
    assign x  = rf_reg[ra];
    assign y  = rf_reg[rb];
    assign z  = rf_reg[rc];
    assign rem_try = {rem_reg, quo_reg[31]} - {1'b0, dvs_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_FETCH;
            ST_FETCH:
                if (cmd_reg == CMD_STEP && !halted_now) state_next = ST_EXEC;
                else state_next = ST_OUT;
            ST_EXEC:
                if (slot_q.op == OP_DIV) state_next = ST_DIV;
                else if (slot_q.op == OP_LOAD) state_next = ST_MEM;
                else state_next = ST_OUT;
            ST_DIV:   if (div_cnt_reg == 6'd32) state_next = ST_OUT;
            ST_MEM:   state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pc_next = pc_reg + 9'd1;
        case (slot_q.op)
            OP_JMP: pc_next = {1'b0, slot_q.a};
            OP_JEQ: if (x == y) pc_next = {1'b0, slot_q.c};
            OP_JGT: if ($signed(x) > $signed(y)) pc_next = {1'b0, slot_q.c};
            OP_JLT: if ($signed(x) < $signed(y)) pc_next = {1'b0, slot_q.c};
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_busy) clr_reg <= clr_reg + CW'(1);
        end
    end

    // memories: clearing pass, item writes, step fetch and data access
    always_ff @(posedge clk)
    begin
        if (clr_busy)
        begin
            if (clr_reg < CW'(IMEM_DEPTH))
                imem[clr_reg[IAW-1:0]] <= '{op: OP_EMPTY, a: 8'd0, b: 8'd0, c: 8'd0};
            if (clr_reg < CW'(DMEM_DEPTH))
                dmem[clr_reg[DAW-1:0]] <= '0;
        end
        else if (state_reg == ST_FETCH && cmd_reg == CMD_WR_SLOT
                 && {1'b0, addr_reg} < 9'(IMEM_DEPTH))
            imem[addr_reg[IAW-1:0]] <= wslot_reg;
        else if (state_reg == ST_FETCH && cmd_reg == CMD_WR_DATA
                 && {1'b0, addr_reg} < 9'(DMEM_DEPTH))
            dmem[addr_reg[DAW-1:0]] <= val_reg;
        else if (state_reg == ST_EXEC && slot_q.op == OP_STORE
                 && x < 32'(DMEM_DEPTH))
            dmem[x[DAW-1:0]] <= y;
        if (state_reg == ST_FETCH)
            slot_q <= imem[pc_reg[IAW-1:0]];
        if (state_reg == ST_EXEC)
            dq <= dmem[slot_q.b[DAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= in_ch.cmd;
            addr_reg  <= in_ch.address;
            wslot_reg <= '{op: in_ch.opcode, a: in_ch.operand_a,
                           b: in_ch.operand_b, c: in_ch.operand_c};
            val_reg   <= in_ch.value;
        end
    end

    assign prod = y * z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++) rf_reg[i] <= '0;
            pc_reg      <= '0;
            stop_reg    <= 1'b0;
            div_cnt_reg <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_OUT)
            begin
                o_valid_reg <= 1'b1;
                o_pc_reg    <= pc_reg;
                o_halt_reg  <= halted_now;
            end
            else if (out_ch.valid && out_ch.ready)
                o_valid_reg <= 1'b0;
            if (state_reg == ST_FETCH)
            begin
                o_ov_reg <= 1'b0; o_val_reg <= '0; o_it_reg <= 1'b0;
                o_sf_reg <= 1'b0; o_op_reg <= OP_EMPTY;
            end
            if (state_reg == ST_EXEC)
            begin
                o_op_reg <= slot_q.op;
                pc_reg   <= pc_next;
                case (slot_q.op)
                    OP_ADD: rf_reg[ra] <= y + z;
                    OP_SUB: rf_reg[ra] <= y - z;
                    OP_MUL: rf_reg[ra] <= prod;
                    OP_DIV:
                    begin
                        div_cnt_reg <= '0;
                        neg_reg <= y[31] ^ z[31];
                        quo_reg <= y[31] ? -y : y;
                        dvs_reg <= z[31] ? -z : z;
                        rem_reg <= '0;
                    end
                    OP_STORE: o_sf_reg <= !(x < 32'(DMEM_DEPTH));
                    OP_WRITE:
                    begin
                        o_ov_reg <= 1'b1; o_val_reg <= x;
                    end
                    OP_READ:
                    begin
                        rf_reg[ra] <= val_reg; o_it_reg <= 1'b1;
                    end
                    OP_STOP: stop_reg <= 1'b1;
                    default: ;
                endcase
            end
            if (state_reg == ST_DIV)
            begin
                if (div_cnt_reg == 6'd32)
                begin
                    if (dvs_reg == '0) rf_reg[ra] <= '0;
                    else rf_reg[ra] <= neg_reg ? -quo_reg : quo_reg;
                end
                else
                begin
                    div_cnt_reg <= div_cnt_reg + 6'd1;
                    if (!rem_try[32])
                    begin
                        rem_reg <= rem_try[31:0];
                        quo_reg <= {quo_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[30:0], quo_reg[31]};
                        quo_reg <= {quo_reg[30:0], 1'b0};
                    end
                end
            end
            if (state_reg == ST_MEM)
                rf_reg[ra] <= ({1'b0, slot_q.b} < 9'(DMEM_DEPTH)) ? dq : '0;
        end
    end

    assign out_ch.valid       = o_valid_reg;
    assign out_ch.pc_after    = o_pc_reg;
    assign out_ch.halted      = o_halt_reg;
    assign out_ch.out_valid   = o_ov_reg;
    assign out_ch.out_value   = o_val_reg;
    assign out_ch.input_taken = o_it_reg;
    assign out_ch.store_fault = o_sf_reg;
    assign out_ch.done_opcode = o_op_reg;

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> !in_ch.ready)
        else $error("item accepted during clearing pass");
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg |-> !in_ch.ready)
        else $error("new item while result pending");
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> div_cnt_reg <= 6'd32)
        else $error("divider count overrun");
    a_result_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT |=> o_valid_reg)
        else $error("result not presented");
endmodule
